>>> rtl/arbpm_pkg.sv
`timescale 1ns / 1ps

package arbpm_pkg;

  // Opcodes of an input request
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_BUFFER     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_BUFFER     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LATE_WAKE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STALL          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_PADDING = 3'd4;

  // Register reset values
  localparam logic [15:0] MIN_BUFFER_RST     = 16'd480;
  localparam logic [15:0] MAX_BUFFER_RST     = 16'd48000;
  localparam logic [31:0] LATE_WAKE_RST      = 32'd200000;
  localparam logic [31:0] STALL_RST          = 32'd2000000;
  localparam logic [15:0] TARGET_PADDING_RST = 16'd1920;

  // Healthy observations needed in a row
  localparam logic [1:0] HEALTHY_NEEDED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [15:0] buf_size;
    logic [15:0] queued_frames;
    logic [62:0] now_ticks;
    logic [62:0] play_pos;
    logic [15:0] release_frames;
  } arbpm_in_t;

  typedef struct packed {
    logic        invalid;
    logic        late_wake;
    logic        underrun;
    logic        stall_flag;
    logic        healthy;
    logic [15:0] credit_frames;
    logic        release_ok;
    logic [31:0] wake_count;
    logic [31:0] late_wake_count;
    logic [31:0] underrun_count;
    logic [62:0] max_wake_gap;
    logic [63:0] submitted_total;
  } arbpm_out_t;

endpackage

>>> rtl/arbpm_if.sv
`timescale 1ns / 1ps

interface arbpm_in_if;
  logic                 valid;
  logic                 ready;
  arbpm_pkg::arbpm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arbpm_out_if;
  logic                  valid;
  logic                  ready;
  arbpm_pkg::arbpm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/audio_render_buffer_pacing_monitor_unit.sv
`timescale 1ns / 1ps
// A request passes through the input register, then the result register, before its
// result is offered on the output.
// Throughput: one request per cycle; the input stalls only while both registers are full
// and the result sink holds ready low. State updates as a request enters the result register.
// Reset (rst_n low, synchronous): clears all statistics, credit and history, restores
// the threshold registers to their defaults and empties both register stages.
module audio_render_buffer_pacing_monitor_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  arbpm_in_if.sink                              in_bus,
  arbpm_out_if.source                           out_bus,
  input  logic                                  cfg_we,
  input  logic [arbpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [arbpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Threshold registers
  logic [15:0] min_buf_r;
  logic [15:0] max_buf_r;
  logic [31:0] late_thr_r;
  logic [31:0] stall_r;
  logic [15:0] target_pad_r;

  // Monitor state
  logic [63:0] submitted_r,  submitted_nxt;
  logic [63:0] consumed_r,   consumed_nxt;
  logic [62:0] last_clock_r, last_clock_nxt;
  logic [62:0] last_wake_r,  last_wake_nxt;
  logic [62:0] last_prog_r,  last_prog_nxt;
  logic [1:0]  hrun_r,       hrun_nxt;
  logic [31:0] wakes_r,      wakes_nxt;
  logic [31:0] dwakes_r,     dwakes_nxt;
  logic [31:0] underruns_r,  underruns_nxt;
  logic [62:0] gap_max_r,    gap_max_nxt;
  logic [15:0] credit_r,     credit_nxt;

  // Pipeline stages
  logic                  item_valid_r;
  arbpm_pkg::arbpm_in_t  item_r;
  logic                  out_valid_r;
  arbpm_pkg::arbpm_out_t out_r, out_nxt;

  logic advance;

  // Move a request forward when the result register is free or being drained
  assign advance      = item_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !item_valid_r || advance;

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_r;

  // Configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_buf_r    <= arbpm_pkg::MIN_BUFFER_RST;
      max_buf_r    <= arbpm_pkg::MAX_BUFFER_RST;
      late_thr_r   <= arbpm_pkg::LATE_WAKE_RST;
      stall_r      <= arbpm_pkg::STALL_RST;
      target_pad_r <= arbpm_pkg::TARGET_PADDING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        arbpm_pkg::REG_MIN_BUFFER:     min_buf_r    <= cfg_wdata[15:0];
        arbpm_pkg::REG_MAX_BUFFER:     max_buf_r    <= cfg_wdata[15:0];
        arbpm_pkg::REG_LATE_WAKE:      late_thr_r   <= cfg_wdata[31:0];
        arbpm_pkg::REG_STALL:          stall_r      <= cfg_wdata[31:0];
        arbpm_pkg::REG_TARGET_PADDING: target_pad_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Observation and release evaluation, all from the input register and current state
  logic        is_obs;
  logic        first_wake;
  logic        obs_bad;
  logic [62:0] gap;
  logic        delayed;
  logic [63:0] consumed;
  logic        progressed;
  logic        prog_upd;
  logic [62:0] since_prog;
  logic        stalled;
  logic        underrun;
  logic [15:0] target;
  logic [15:0] credit_obs;
  logic [1:0]  hrun_obs;
  logic        healthy;
  logic [64:0] rel_sum;
  logic        rel_ok;

  always_comb begin
    is_obs     = (item_r.opcode == arbpm_pkg::OP_OBSERVE);
    first_wake = (last_wake_r == '0);

    obs_bad = (item_r.buf_size < min_buf_r) ||
              (item_r.buf_size > max_buf_r) ||
              (item_r.queued_frames > item_r.buf_size) ||
              ({48'd0, item_r.queued_frames} > submitted_r) ||
              (item_r.now_ticks == '0) ||
              (!first_wake && (item_r.now_ticks < last_wake_r)) ||
              (item_r.play_pos < last_clock_r);

    // No gap is measured on the first wake
    gap     = item_r.now_ticks - last_wake_r;
    delayed = !first_wake && (gap > {31'd0, late_thr_r});

    consumed   = submitted_r - {48'd0, item_r.queued_frames};
    progressed = (consumed > consumed_r) && (item_r.play_pos > last_clock_r);
    prog_upd   = first_wake || progressed;

    // When progress time moves to now the distance is zero
    since_prog = item_r.now_ticks - last_prog_r;
    if (prog_upd) begin
      stalled = (stall_r == '0);
    end else begin
      stalled = (item_r.now_ticks >= last_prog_r) && (since_prog >= {31'd0, stall_r});
    end

    // Healthy run moves only on progress: advance on a clean one, drop otherwise
    hrun_obs = hrun_r;
    if (progressed) begin
      if ((item_r.queued_frames != '0) && !delayed) begin
        if (hrun_r < arbpm_pkg::HEALTHY_NEEDED) begin
          hrun_obs = hrun_r + 2'd1;
        end
      end else begin
        hrun_obs = '0;
      end
    end
    healthy = (hrun_obs >= arbpm_pkg::HEALTHY_NEEDED) && !stalled;

    underrun = (submitted_r != '0) && (item_r.queued_frames == '0);

    target = (target_pad_r < item_r.buf_size) ? target_pad_r : item_r.buf_size;
    if (!stalled && (item_r.queued_frames < target)) begin
      credit_obs = target - item_r.queued_frames;
    end else begin
      credit_obs = '0;
    end

    // Release is rejected on zero, on excess over credit, or on total overflow
    rel_sum = {1'b0, submitted_r} + {49'd0, item_r.release_frames};
    rel_ok  = (item_r.release_frames != '0) && (item_r.release_frames <= credit_r) &&
              !rel_sum[64];
  end

  // Next state and result
  always_comb begin
    submitted_nxt  = submitted_r;
    consumed_nxt   = consumed_r;
    last_clock_nxt = last_clock_r;
    last_wake_nxt  = last_wake_r;
    last_prog_nxt  = last_prog_r;
    hrun_nxt       = hrun_r;
    wakes_nxt      = wakes_r;
    dwakes_nxt     = dwakes_r;
    underruns_nxt  = underruns_r;
    gap_max_nxt    = gap_max_r;
    credit_nxt     = credit_r;

    out_nxt = '0;

    if (is_obs) begin
      // Any observation drops the previous credit
      credit_nxt = '0;
      if (obs_bad) begin
        out_nxt.invalid = 1'b1;
      end else begin
        if (wakes_r != '1) wakes_nxt = wakes_r + 32'd1;
        if (!first_wake && (gap > gap_max_r)) gap_max_nxt = gap;
        if (delayed && (dwakes_r != '1)) dwakes_nxt = dwakes_r + 32'd1;
        if (underrun && (underruns_r != '1)) underruns_nxt = underruns_r + 32'd1;
        if (prog_upd) last_prog_nxt = item_r.now_ticks;
        hrun_nxt       = hrun_obs;
        consumed_nxt   = consumed;
        last_clock_nxt = item_r.play_pos;
        last_wake_nxt  = item_r.now_ticks;
        credit_nxt     = credit_obs;

        out_nxt.late_wake  = delayed;
        out_nxt.underrun   = underrun;
        out_nxt.stall_flag = stalled;
        out_nxt.healthy    = healthy;
      end
    end else if (rel_ok) begin
      submitted_nxt      = rel_sum[63:0];
      credit_nxt         = '0;
      out_nxt.release_ok = 1'b1;
    end

    out_nxt.credit_frames   = credit_nxt;
    out_nxt.wake_count      = wakes_nxt;
    out_nxt.late_wake_count = dwakes_nxt;
    out_nxt.underrun_count  = underruns_nxt;
    out_nxt.max_wake_gap    = gap_max_nxt;
    out_nxt.submitted_total = submitted_nxt;
  end

  // State registers: commit only when a request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      submitted_r  <= '0;
      consumed_r   <= '0;
      last_clock_r <= '0;
      last_wake_r  <= '0;
      last_prog_r  <= '0;
      hrun_r       <= '0;
      wakes_r      <= '0;
      dwakes_r     <= '0;
      underruns_r  <= '0;
      gap_max_r    <= '0;
      credit_r     <= '0;
    end else if (advance) begin
      submitted_r  <= submitted_nxt;
      consumed_r   <= consumed_nxt;
      last_clock_r <= last_clock_nxt;
      last_wake_r  <= last_wake_nxt;
      last_prog_r  <= last_prog_nxt;
      hrun_r       <= hrun_nxt;
      wakes_r      <= wakes_nxt;
      dwakes_r     <= dwakes_nxt;
      underruns_r  <= underruns_nxt;
      gap_max_r    <= gap_max_nxt;
      credit_r     <= credit_nxt;
    end
  end

  // Input register: hold a request until it advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      item_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r <= in_bus.data;
    end
  end

  // Result register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/arbpm_checker.sv
`timescale 1ns / 1ps

module arbpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] wake_count,
  input logic [63:0] submitted_total
);

  logic [31:0] last_wakes_r;
  logic [63:0] last_total_r;

  // Track the statistics of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wakes_r <= '0;
      last_total_r <= '0;
    end else if (out_valid && out_ready) begin
      last_wakes_r <= wake_count;
      last_total_r <= submitted_total;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> submitted_total >= last_total_r)
    else $error("submitted total went backwards");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> wake_count >= last_wakes_r)
    else $error("wake count went backwards");

endmodule

bind audio_render_buffer_pacing_monitor_unit arbpm_checker u_arbpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .wake_count      (out_bus.data.wake_count),
  .submitted_total (out_bus.data.submitted_total)
);
